// ----- rtl/core/bwl_pkg.sv -----
`default_nettype none
package bwl_pkg;

  localparam int WORD_BITS     = 64;
  localparam int WIDX_W        = 6;   // word index = bit_addr >> 6
  localparam int POS_W         = 6;   // bit position = bit_addr & 63
  localparam int LEN_W         = 7;
  localparam int MAX_WORDS     = 2 ** WIDX_W;  // words reachable by a 6-bit index
  localparam int NUM_WORDS_DEF = 64;

  typedef enum logic [1:0] {
    REQ_SET     = 2'd0,
    REQ_CLR     = 2'd1,
    REQ_TEST    = 2'd2,
    REQ_CLR_ALL = 2'd3
  } req_type_e;

  typedef struct packed {
    req_type_e                 req_type;
    logic [WIDX_W+POS_W-1:0]   bit_addr;
  } req_t;

  typedef struct packed {
    logic             bit_value;
    logic [LEN_W-1:0] used_words;
  } res_t;

  // word write-back toward the store
  typedef struct packed {
    logic                 we;
    logic                 clr_all;
    logic [WIDX_W-1:0]    widx;
    logic [WORD_BITS-1:0] data;
  } st_wr_t;

  // nonzero-flag update toward the length tracker
  typedef struct packed {
    logic              we;
    logic              clr_all;
    logic [WIDX_W-1:0] widx;
    logic              nz;
  } nz_upd_t;

endpackage
`default_nettype wire

// ----- rtl/core/bitset_with_logical_length.sv -----
`default_nettype none
// Channel   Ports                 Transfer
// -------   --------------------  ------------------------------------------
// request   start, busy, req_i    edge with start high and busy low
// result    done_o, res_o         one-cycle strobe, receiver cannot stall
//
// The accept edge issues the word read, the busy cycle modifies the word and
// writes it back, and the result strobes in the cycle after that. A new
// request is not taken while busy, during the read-modify-write of the word
// store. Reset and clear all wipe the valid bits and the per-word nonzero
// flags at once, so no clearing pass is needed. The length is one past the
// highest nonzero word, from a priority encoder. The receiver cannot stall.
module bitset_with_logical_length import bwl_pkg::*; #(
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  input  wire req_t req_i,
  output logic      done_o,
  output res_t      res_o
);

  localparam int Depth = (NUM_WORDS < MAX_WORDS) ? NUM_WORDS : MAX_WORDS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RMW  = 2'b10
  } state_e;

  state_e            state_q, state_d;
  req_type_e         req_q;
  logic [WIDX_W-1:0] widx_q;
  logic [POS_W-1:0]  pos_q;
  logic              done_q;
  logic              val_q, val_d;

  logic                 accept;
  logic [WORD_BITS-1:0] word;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] new_word;
  logic                 in_store;
  st_wr_t               st_wr;
  nz_upd_t              nz_upd;
  logic [LEN_W-1:0]     len;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q == ST_RMW);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_RMW;
      ST_RMW:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_i.req_type;
      widx_q <= req_i.bit_addr[WIDX_W+POS_W-1:POS_W];
      pos_q  <= req_i.bit_addr[POS_W-1:0];
    end
    if (busy) begin
      val_q <= val_d;
    end
  end

  bwl_store #(
    .NUM_WORDS (NUM_WORDS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_widx_i (req_i.bit_addr[WIDX_W+POS_W-1:POS_W]),
    .wr_i      (st_wr),
    .rd_data_o (word)
  );

  // modify stage; words beyond the store are never touched
  assign in_store = {1'b0, widx_q} < LEN_W'(Depth);
  assign mask     = WORD_BITS'(1) << pos_q;

  always_comb begin
    new_word = word;
    val_d    = 1'b0;
    st_wr    = '0;
    nz_upd   = '0;
    case (req_q)
      REQ_SET: begin
        new_word = word | mask;
        st_wr.we = busy && in_store;
      end
      REQ_CLR: begin
        // a word past the length is zero, so this is a no-op there
        new_word = word & ~mask;
        st_wr.we = busy && in_store;
      end
      REQ_TEST: begin
        val_d = in_store && word[pos_q];
      end
      REQ_CLR_ALL: begin
        st_wr.clr_all = busy;
      end
      default: ;
    endcase
    st_wr.widx     = widx_q;
    st_wr.data     = new_word;
    nz_upd.we      = st_wr.we;
    nz_upd.clr_all = st_wr.clr_all;
    nz_upd.widx    = widx_q;
    nz_upd.nz      = |new_word;
  end

  bwl_len #(
    .NUM_WORDS (NUM_WORDS)
  ) u_len (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (nz_upd),
    .len_o  (len)
  );

  // length register holds until the next write cycle, past the strobe
  assign done_o = done_q;
  assign res_o  = '{bit_value: val_q, used_words: len};

endmodule
`default_nettype wire

// ----- rtl/core/bwl_store.sv -----
`default_nettype none
module bwl_store import bwl_pkg::*; #(
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 rd_en_i,
  input  wire logic [WIDX_W-1:0]    rd_widx_i,
  input  wire st_wr_t               wr_i,
  output logic [WORD_BITS-1:0]      rd_data_o
);

  localparam int Depth = (NUM_WORDS < MAX_WORDS) ? NUM_WORDS : MAX_WORDS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [WORD_BITS-1:0] mem_q [Depth];
  logic [Depth-1:0]     vld_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_vld_q;

  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  assign rd_addr = rd_widx_i[AW-1:0];
  assign wr_addr = wr_i.widx[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // valid bits stand in for a cleared array
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.clr_all) begin
        vld_q <= '0;
      end else if (wr_i.we) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule
`default_nettype wire

// ----- rtl/core/bwl_len.sv -----
`default_nettype none
module bwl_len import bwl_pkg::*; #(
  parameter int NUM_WORDS = NUM_WORDS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire nz_upd_t          upd_i,
  output logic [LEN_W-1:0]      len_o
);

  localparam int Depth = (NUM_WORDS < MAX_WORDS) ? NUM_WORDS : MAX_WORDS;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Depth-1:0] nz_q, nz_d;
  logic [LEN_W-1:0] len_q, len_d;

  always_comb begin
    nz_d = nz_q;
    if (upd_i.clr_all) begin
      nz_d = '0;
    end else if (upd_i.we) begin
      nz_d[upd_i.widx[AW-1:0]] = upd_i.nz;
    end
  end

  // priority encode: one past the highest nonzero word
  always_comb begin
    len_d = '0;
    for (int i = 0; i < Depth; i++) begin
      if (nz_d[i]) begin
        len_d = LEN_W'(i + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nz_q  <= '0;
      len_q <= '0;
    end else begin
      nz_q  <= nz_d;
      len_q <= len_d;
    end
  end

  assign len_o = len_q;

endmodule
`default_nettype wire
